// ===== src/swed_pkg.sv =====
// Shared types and constants for the side wall end detector.
// No dependencies.
package swed_pkg;

  localparam int unsigned DELTA_W = 13;
  localparam int unsigned SLOPE_W = 14;
  localparam int unsigned THR_W   = 12;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] FALL_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_INIT   = 2'd2,
    OP_SPARE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RIGHT_HIGH = 3'd0,
    CFG_RIGHT_LOW  = 3'd1,
    CFG_LEFT_HIGH  = 3'd2,
    CFG_LEFT_LOW   = 3'd3,
    CFG_FALL       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              flag;
    logic [CNT_W-1:0]  cnt;
    logic              latched;
    logic [DIST_W-1:0] ldist;
  } side_state_t;

endpackage

// ===== src/side_wall_end_detector_core.sv =====
// Side wall end detector: input stage, per-side hysteresis/fall/latch logic, result register.
// Depends on swed_pkg.
//
// An item passes the input register, then the result register, where a result is held while
// out_ready is low. Throughput: one item per cycle while out_ready is high, limited by the
// combinational state update between the two registers. Reset (rst_n low, synchronous) clears
// all detector state, thresholds and both pipeline valid flags; cfg_ready is always high.
module side_wall_end_detector_core
  import swed_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [THR_W-1:0]            cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic signed [DELTA_W-1:0]   in_right_delta,
  input  logic signed [DELTA_W-1:0]   in_left_delta,
  input  logic                        in_gate_on,
  input  logic signed [DIST_W-1:0]    in_travel_distance,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_right_present,
  output logic                        out_left_present,
  output logic                        out_right_end_found,
  output logic                        out_left_end_found,
  output logic signed [DIST_W-1:0]    out_right_end_distance,
  output logic signed [DIST_W-1:0]    out_left_end_distance,
  output logic signed [SLOPE_W-1:0]   out_right_slope,
  output logic signed [SLOPE_W-1:0]   out_left_slope,
  output logic                        out_end_event
);

  function automatic logic gt_thr(logic [DELTA_W-1:0] d, logic [THR_W-1:0] t);
    return $signed({d[DELTA_W-1], d}) > $signed({2'b00, t});
  endfunction

  function automatic logic lt_thr(logic [DELTA_W-1:0] d, logic [THR_W-1:0] t);
    return $signed({d[DELTA_W-1], d}) < $signed({2'b00, t});
  endfunction

  function automatic side_state_t side_step(
    logic [DELTA_W-1:0] d, logic [SLOPE_W-1:0] slope, logic [THR_W-1:0] hi,
    logic [THR_W-1:0] lo, logic [THR_W-1:0] fall, side_state_t cur, logic gate,
    logic [DIST_W-1:0] trip_dist);
    side_state_t      res;
    logic             now;
    logic             fall_hit;
    res = cur;
    now = cur.flag;
    if (cur.flag) begin
      if (lt_thr(d, lo)) now = 1'b0;
    end else if (gt_thr(d, hi)) begin
      now = 1'b1;
    end
    fall_hit = $signed({slope[SLOPE_W-1], slope}) < -$signed({3'b000, fall});
    res.cnt = (now && fall_hit) ? cur.cnt + 2'd1 : '0;
    if (res.cnt >= FALL_LIMIT) begin
      now     = 1'b0;
      res.cnt = '0;
    end
    if (cur.flag && !now && gate && !cur.latched) begin
      res.latched = 1'b1;
      res.ldist   = trip_dist;
    end
    res.flag = now;
    return res;
  endfunction

  logic [THR_W-1:0] right_high_r, right_low_r, left_high_r, left_low_r, fall_thr_r;

  logic                 s1_valid_r, s1_valid_nxt;
  op_t                  s1_op_r;
  logic [DELTA_W-1:0]   s1_rd_r, s1_ld_r;
  logic                 s1_gate_r;
  logic [DIST_W-1:0]    s1_dist_r;

  side_state_t          right_r, left_r, right_nxt, left_nxt;
  logic [DELTA_W-1:0]   right_prev_r, left_prev_r, right_prev_nxt, left_prev_nxt;
  logic                 primed_r, primed_nxt;
  logic [SLOPE_W-1:0]   right_slope_nxt, left_slope_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 advance, fire, in_xfer;

  side_state_t          right_cur, left_cur;
  logic [DELTA_W-1:0]   right_prev_cur, left_prev_cur;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_xfer   = in_valid && in_ready;
  assign fire      = s1_valid_r && advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (fire) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_comb begin
    right_cur      = right_r;
    left_cur       = left_r;
    right_prev_cur = right_prev_r;
    left_prev_cur  = left_prev_r;
    if (!primed_r) begin
      right_cur      = '{flag: gt_thr(s1_rd_r, right_high_r), cnt: '0, latched: 1'b0,
                         ldist: '0};
      left_cur       = '{flag: gt_thr(s1_ld_r, left_high_r), cnt: '0, latched: 1'b0,
                         ldist: '0};
      right_prev_cur = s1_rd_r;
      left_prev_cur  = s1_ld_r;
    end
    right_slope_nxt = SLOPE_W'($signed(s1_rd_r)) - SLOPE_W'($signed(right_prev_cur));
    left_slope_nxt  = SLOPE_W'($signed(s1_ld_r)) - SLOPE_W'($signed(left_prev_cur));
    right_nxt = side_step(s1_rd_r, right_slope_nxt, right_high_r, right_low_r, fall_thr_r,
                          right_cur, s1_gate_r, s1_dist_r);
    left_nxt  = side_step(s1_ld_r, left_slope_nxt, left_high_r, left_low_r, fall_thr_r,
                          left_cur, s1_gate_r, s1_dist_r);
    right_prev_nxt = s1_rd_r;
    left_prev_nxt  = s1_ld_r;
    primed_nxt     = 1'b1;
    case (s1_op_r)
      OP_CLEAR: begin
        right_nxt       = '0;
        left_nxt        = '0;
        right_prev_nxt  = '0;
        left_prev_nxt   = '0;
        primed_nxt      = 1'b0;
        right_slope_nxt = '0;
        left_slope_nxt  = '0;
      end
      OP_INIT: begin
        right_nxt       = '{flag: gt_thr(s1_rd_r, right_high_r), cnt: '0, latched: 1'b0,
                            ldist: '0};
        left_nxt        = '{flag: gt_thr(s1_ld_r, left_high_r), cnt: '0, latched: 1'b0,
                            ldist: '0};
        right_slope_nxt = '0;
        left_slope_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_high_r <= '0;
      right_low_r  <= '0;
      left_high_r  <= '0;
      left_low_r   <= '0;
      fall_thr_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RIGHT_HIGH: right_high_r <= cfg_wdata;
        CFG_RIGHT_LOW:  right_low_r  <= cfg_wdata;
        CFG_LEFT_HIGH:  left_high_r  <= cfg_wdata;
        CFG_LEFT_LOW:   left_low_r   <= cfg_wdata;
        CFG_FALL:       fall_thr_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      right_r      <= '0;
      left_r       <= '0;
      right_prev_r <= '0;
      left_prev_r  <= '0;
      primed_r     <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        right_r      <= right_nxt;
        left_r       <= left_nxt;
        right_prev_r <= right_prev_nxt;
        left_prev_r  <= left_prev_nxt;
        primed_r     <= primed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= op_t'(in_op);
      s1_rd_r   <= in_right_delta;
      s1_ld_r   <= in_left_delta;
      s1_gate_r <= in_gate_on;
      s1_dist_r <= in_travel_distance;
    end
    if (fire) begin
      out_right_present      <= right_nxt.flag;
      out_left_present       <= left_nxt.flag;
      out_right_end_found    <= right_nxt.latched;
      out_left_end_found     <= left_nxt.latched;
      out_right_end_distance <= right_nxt.ldist;
      out_left_end_distance  <= left_nxt.ldist;
      out_right_slope        <= right_slope_nxt;
      out_left_slope         <= left_slope_nxt;
      out_end_event          <= s1_gate_r && (right_nxt.latched || left_nxt.latched);
    end
  end

  assign out_valid = out_valid_r;

  a_right_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    right_r.cnt < FALL_LIMIT && left_r.cnt < FALL_LIMIT)
    else $error("fall count reached limit in stored state");

  a_event_needs_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_event |-> out_right_end_found || out_left_end_found)
    else $error("end event without a latched wall end");

  a_latch_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(right_r.latched) |-> !right_r.flag)
    else $error("right end latched while wall flag still set");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item did not reach result register");

endmodule
